// ===== src/gf2sfc_pkg.sv =====
// Package for the GF(2) systematic-form check core.
// Holds field widths, register indexes, reset values and the word types.
// No dependencies.
`default_nettype none

package gf2sfc_pkg;

  localparam int ROW_IDX_W  = 5;
  localparam int COL_IDX_W  = 6;
  localparam int RANK_W     = 6;
  localparam int NUM_ROWS_W = 6;
  localparam int NUM_COLS_W = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = NUM_ROWS_W'(32);
  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = NUM_COLS_W'(64);

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic                 last;
  } in_t;

  typedef struct packed {
    logic              systematic;
    logic [RANK_W-1:0] rank;
  } out_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } edge_ctl_t;

endpackage

`default_nettype wire

// ===== src/gf2sfc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gf2sfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/gf2sfc_edge_store.sv =====
// Edge matrix store: RAM rows with per-row valid bits; invalid rows read as zero.
// Depends on gf2sfc_pkg and gf2sfc_ram.
`default_nettype none

module gf2sfc_edge_store #(
  parameter int WIDTH = gf2sfc_pkg::MAX_COLS_DEF,
  parameter int DEPTH = gf2sfc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire gf2sfc_pkg::edge_ctl_t     ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  wire logic [WIDTH-1:0]          wr_data_i,
  output logic      [WIDTH-1:0]          rd_data_o
);

  logic [DEPTH-1:0] valid_q;
  logic             rd_vld_q;
  logic [WIDTH-1:0] ram_rd;

  gf2sfc_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ctl_i.wr),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (wr_data_i),
    .rd_en_i   (ctl_i.rd),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? ram_rd : '0;

endmodule

`default_nettype wire

// ===== src/gf2_systematic_form_check_core.sv =====
// GF(2) systematic-form check core: top level with sequencer and work matrix.
// Depends on gf2sfc_pkg, gf2sfc_ram and gf2sfc_edge_store.
//
// Each input word adds one (row, column) edge to the stored matrix, if both
// lie within the effective size, by a read-modify-write of one edge RAM row.
// A word marked last then copies the matrix into the work RAM and eliminates
// it one row access at a time through a single shared row XOR/compare step:
// the copy reads and writes each effective row; for each pivot the pivot row
// is read, the rows below are searched for a set pivot bit and the first hit
// is swapped in; a clear pass then XORs the pivot row into every other row
// that has that bit set; a last pass counts the nonzero rows as the rank and
// checks the diagonal. The input stalls meanwhile. A failed check clears the
// edge store (per-row valid bits). The result word is one output register.
`default_nettype none

module gf2_systematic_form_check_core #(
  parameter int MAX_ROWS = gf2sfc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gf2sfc_pkg::MAX_COLS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire gf2sfc_pkg::in_t                    in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output gf2sfc_pkg::out_t                        out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [gf2sfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gf2sfc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_COPY_RD, S_COPY_WR, S_PIV_RD, S_PIV_CHK, S_SRCH_RD,
    S_SRCH_CHK, S_SWAP_WR, S_XOR_RD, S_XOR_WR, S_CMP_RD, S_CMP_CHK, S_DONE
  } state_e;

  state_e                                state_q;
  logic [gf2sfc_pkg::NUM_ROWS_W-1:0]     num_rows_q;
  logic [gf2sfc_pkg::NUM_COLS_W-1:0]     num_cols_q;
  logic [CNT_W-1:0]                      i_q, j_q, rank_q;
  logic                                  sys_q;
  logic [MAX_COLS-1:0]                   piv_q;
  logic [ROW_AW-1:0]                     row_q;
  logic [COL_AW-1:0]                     col_q;
  logic                                  last_q, in_range_q;
  logic                                  out_valid_q;
  gf2sfc_pkg::out_t                      out_data_q;

  logic [6:0]          eff_rows, eff_cols;
  logic [CNT_W-1:0]    rows_c, i_nxt, j_nxt;
  logic                in_acc;
  logic [MAX_COLS-1:0] col_mask;

  gf2sfc_pkg::edge_ctl_t edge_ctl;
  logic [ROW_AW-1:0]     edge_rd_addr;
  logic [MAX_COLS-1:0]   edge_rd, edge_wr_data;

  logic                  work_rd_en, work_wr_en;
  logic [ROW_AW-1:0]     work_rd_addr, work_wr_addr;
  logic [MAX_COLS-1:0]   work_rd, work_wr_data;

  function automatic logic bit_at(input logic [MAX_COLS-1:0] row,
                                  input logic [CNT_W-1:0]    idx);
    bit_at = (int'(idx) < MAX_COLS) && row[COL_AW'(idx)];
  endfunction

  assign eff_rows = ({1'b0, num_rows_q} > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : {1'b0, num_rows_q};
  assign eff_cols = (num_cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : num_cols_q;
  assign rows_c   = CNT_W'(eff_rows);
  assign i_nxt    = i_q + CNT_W'(1);
  assign j_nxt    = j_q + CNT_W'(1);
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign col_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    edge_ctl.rd  = in_acc || (state_q == S_COPY_RD);
    edge_ctl.wr  = (state_q == S_EDGE) && in_range_q;
    edge_ctl.clr = (state_q == S_DONE) && !sys_q && (!out_valid_q || !out_stall_i);
    edge_rd_addr = (state_q == S_IDLE) ? ROW_AW'(in_data_i.row_index) : j_q[ROW_AW-1:0];
    edge_wr_data = edge_rd | col_mask;

    work_rd_en   = 1'b0;
    work_rd_addr = j_q[ROW_AW-1:0];
    work_wr_en   = 1'b0;
    work_wr_addr = j_q[ROW_AW-1:0];
    work_wr_data = work_rd;
    unique case (state_q)
      S_COPY_WR: begin
        work_wr_en   = 1'b1;
        work_wr_data = edge_rd;
      end
      S_PIV_RD: begin
        work_rd_en   = 1'b1;
        work_rd_addr = i_q[ROW_AW-1:0];
      end
      S_SRCH_RD, S_CMP_RD: begin
        work_rd_en = 1'b1;
      end
      S_XOR_RD: begin
        work_rd_en = (j_q != i_q);
      end
      S_SRCH_CHK: begin
        work_wr_en   = bit_at(work_rd, i_q);
        work_wr_data = piv_q;
      end
      S_SWAP_WR: begin
        work_wr_en   = 1'b1;
        work_wr_addr = i_q[ROW_AW-1:0];
        work_wr_data = piv_q;
      end
      S_XOR_WR: begin
        work_wr_en   = bit_at(work_rd, i_q);
        work_wr_data = work_rd ^ piv_q;
      end
      default: begin
      end
    endcase
  end

  gf2sfc_edge_store #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_edge_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (edge_ctl),
    .rd_addr_i (edge_rd_addr),
    .wr_addr_i (row_q),
    .wr_data_i (edge_wr_data),
    .rd_data_o (edge_rd)
  );

  gf2sfc_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_work_ram (
    .clk_i     (clk_i),
    .wr_en_i   (work_wr_en),
    .wr_addr_i (work_wr_addr),
    .wr_data_i (work_wr_data),
    .rd_en_i   (work_rd_en),
    .rd_addr_i (work_rd_addr),
    .rd_data_o (work_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      num_rows_q  <= gf2sfc_pkg::NUM_ROWS_RST;
      num_cols_q  <= gf2sfc_pkg::NUM_COLS_RST;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      sys_q       <= 1'b1;
      piv_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      last_q      <= 1'b0;
      in_range_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          gf2sfc_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i[gf2sfc_pkg::NUM_ROWS_W-1:0];
          gf2sfc_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i[gf2sfc_pkg::NUM_COLS_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            row_q      <= ROW_AW'(in_data_i.row_index);
            col_q      <= COL_AW'(in_data_i.col_index);
            last_q     <= in_data_i.last;
            in_range_q <= ({2'b0, in_data_i.row_index} < eff_rows) &&
                          ({1'b0, in_data_i.col_index} < eff_cols);
            state_q    <= S_EDGE;
          end
        end
        S_EDGE: begin
          j_q    <= '0;
          i_q    <= '0;
          rank_q <= '0;
          sys_q  <= 1'b1;
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (rows_c == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_COPY_RD;
          end
        end
        S_COPY_RD: begin
          state_q <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (j_nxt == rows_c) begin
            state_q <= S_PIV_RD;
          end else begin
            j_q     <= j_nxt;
            state_q <= S_COPY_RD;
          end
        end
        S_PIV_RD: begin
          state_q <= S_PIV_CHK;
        end
        S_PIV_CHK: begin
          piv_q <= work_rd;
          if (bit_at(work_rd, i_q) || (i_nxt == rows_c)) begin
            j_q     <= '0;
            state_q <= S_XOR_RD;
          end else begin
            j_q     <= i_nxt;
            state_q <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CHK;
        end
        S_SRCH_CHK: begin
          if (bit_at(work_rd, i_q)) begin
            piv_q   <= work_rd;
            state_q <= S_SWAP_WR;
          end else if (j_nxt == rows_c) begin
            j_q     <= '0;
            state_q <= S_XOR_RD;
          end else begin
            j_q     <= j_nxt;
            state_q <= S_SRCH_RD;
          end
        end
        S_SWAP_WR: begin
          j_q     <= '0;
          state_q <= S_XOR_RD;
        end
        S_XOR_RD, S_XOR_WR: begin
          if (state_q == S_XOR_RD && j_q != i_q) begin
            state_q <= S_XOR_WR;
          end else if (j_nxt != rows_c) begin
            j_q     <= j_nxt;
            state_q <= S_XOR_RD;
          end else if (i_nxt == rows_c) begin
            j_q     <= '0;
            state_q <= S_CMP_RD;
          end else begin
            i_q     <= i_nxt;
            state_q <= S_PIV_RD;
          end
        end
        S_CMP_RD: begin
          state_q <= S_CMP_CHK;
        end
        S_CMP_CHK: begin
          if (work_rd != '0) begin
            if (!bit_at(work_rd, rank_q)) begin
              sys_q <= 1'b0;
            end
            rank_q <= rank_q + CNT_W'(1);
          end
          if (j_nxt == rows_c) begin
            state_q <= S_DONE;
          end else begin
            j_q     <= j_nxt;
            state_q <= S_CMP_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q           <= 1'b1;
            out_data_q.systematic <= sys_q;
            out_data_q.rank       <= gf2sfc_pkg::RANK_W'(rank_q);
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
